### hdl/gqi_pkg.sv
`default_nettype none

package gqi_pkg;

   localparam int unsigned CoordWidth = 32;
   localparam int unsigned AddrWidth  = 24;
   localparam int unsigned TexWidth   = 16;
   localparam int unsigned LineWidth  = 13;
   localparam int unsigned OrgWidth   = 12;
   localparam int unsigned CountWidth = 6;
   localparam int unsigned ColWidth   = 3;
   localparam int unsigned ReqWidth   = 2 * OrgWidth + 8 * CoordWidth;
   localparam int unsigned RspWidth   = AddrWidth + TexWidth;

   localparam logic [LineWidth-1:0]  LineWidthReset = 13'd320;
   localparam logic [CountWidth-1:0] LastCount      = 6'd63;
   localparam logic [ColWidth-1:0]   LastCol        = 3'd7;

   typedef logic [CoordWidth-1:0] coord_type;

   // one cell ready for the walker: first row, next row edges and steps
   typedef struct packed {
      coord_type              u;
      coord_type              v;
      coord_type              du;
      coord_type              dv;
      coord_type              left_u;
      coord_type              right_u;
      coord_type              left_v;
      coord_type              right_v;
      coord_type              step_lu;
      coord_type              step_ru;
      coord_type              step_lv;
      coord_type              step_rv;
      logic [AddrWidth-1:0]   row_base;
   } cell_type;

   // (b - a) over 33 bits, arithmetic shift right by 3
   function automatic coord_type step_of(input coord_type a, input coord_type b);
      logic [CoordWidth:0] d;
      d = {b[CoordWidth-1], b} - {a[CoordWidth-1], a};
      return {{2{d[CoordWidth]}}, d[CoordWidth:3]};
   endfunction

endpackage

`default_nettype wire

### hdl/gqi_front.sv
`default_nettype none

module gqi_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [gqi_pkg::ReqWidth-1:0]  req_tdata,
   input  wire logic [gqi_pkg::LineWidth-1:0] line_width,
   output logic                               q_push,
   input  wire logic                          q_ready,
   output gqi_pkg::cell_type                  q_data
);
   import gqi_pkg::*;

   logic                       s1_valid_ff, s1_valid_in;
   logic                       s2_valid_ff, s2_valid_in;
   logic                       s1_take, s2_take;
   logic [OrgWidth-1:0]        ox_ff;
   logic [AddrWidth-1:0]       prod_ff;
   coord_type                  tlu_ff, tlv_ff, tru_ff, trv_ff;
   coord_type                  du_ff, dv_ff, dlu_ff, dru_ff, dlv_ff, drv_ff;
   cell_type                   cell_ff, cell_in;
   logic [OrgWidth-1:0]        ox, oy;
   coord_type                  tlu, tlv, tru, trv, blu, blv, bru, brv;
   logic [OrgWidth+LineWidth-1:0] prod;

   assign ox  = req_tdata[11:0];
   assign oy  = req_tdata[23:12];
   assign tlu = req_tdata[55:24];
   assign tlv = req_tdata[87:56];
   assign tru = req_tdata[119:88];
   assign trv = req_tdata[151:120];
   assign blu = req_tdata[183:152];
   assign blv = req_tdata[215:184];
   assign bru = req_tdata[247:216];
   assign brv = req_tdata[279:248];
   assign prod = oy * line_width;

   assign s2_take    = !s2_valid_ff || q_ready;
   assign s1_take    = !s1_valid_ff || s2_take;
   assign req_tready = s1_take;
   assign q_push     = s2_valid_ff;
   assign q_data     = cell_ff;

   always_comb begin
      s1_valid_in = s1_take ? req_tvalid : s1_valid_ff;
      s2_valid_in = s2_take ? s1_valid_ff : s2_valid_ff;
   end

   always_comb begin
      cell_in.u        = tlu_ff;
      cell_in.v        = tlv_ff;
      cell_in.du       = du_ff;
      cell_in.dv       = dv_ff;
      cell_in.left_u   = tlu_ff + dlu_ff;
      cell_in.right_u  = tru_ff + dru_ff;
      cell_in.left_v   = tlv_ff + dlv_ff;
      cell_in.right_v  = trv_ff + drv_ff;
      cell_in.step_lu  = dlu_ff;
      cell_in.step_ru  = dru_ff;
      cell_in.step_lv  = dlv_ff;
      cell_in.step_rv  = drv_ff;
      cell_in.row_base = prod_ff + {{(AddrWidth-OrgWidth){1'b0}}, ox_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_take) begin
         ox_ff   <= ox;
         prod_ff <= prod[AddrWidth-1:0];
         tlu_ff  <= tlu;
         tlv_ff  <= tlv;
         tru_ff  <= tru;
         trv_ff  <= trv;
         du_ff   <= step_of(tlu, tru);
         dv_ff   <= step_of(tlv, trv);
         dlu_ff  <= step_of(tlu, blu);
         dru_ff  <= step_of(tru, bru);
         dlv_ff  <= step_of(tlv, blv);
         drv_ff  <= step_of(trv, brv);
      end
      if (s2_take) begin
         cell_ff <= cell_in;
      end
   end

endmodule

`default_nettype wire

### hdl/gqi_fifo.sv
`default_nettype none

module gqi_fifo #(
   parameter int unsigned DEPTH = 2
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   output logic                   push_ready,
   input  wire gqi_pkg::cell_type push_data,
   output logic                   pop_valid,
   input  wire logic              pop,
   output gqi_pkg::cell_type      pop_data
);
   import gqi_pkg::*;

   localparam int unsigned PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CntWidth = $clog2(DEPTH + 1);
   localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(DEPTH - 1);
   localparam logic [CntWidth-1:0] Full    = CntWidth'(DEPTH);

   cell_type                mem [DEPTH];
   logic [PtrWidth-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0]     count_ff, count_in;
   logic                    do_push, do_pop;

   assign push_ready = (count_ff != Full);
   assign pop_valid  = (count_ff != '0);
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_valid;
   assign pop_data   = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

### hdl/gqi_back.sv
`default_nettype none

module gqi_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [gqi_pkg::LineWidth-1:0] line_width,
   input  wire logic                          q_valid,
   output logic                               q_pop,
   input  wire gqi_pkg::cell_type             q_data,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic [gqi_pkg::RspWidth-1:0]       rsp_tdata,
   output logic                               rsp_tlast
);
   import gqi_pkg::*;

   logic                   busy_ff, busy_in;
   logic [CountWidth-1:0]  cnt_ff, cnt_in;
   logic                   out_valid_ff, out_valid_in;
   logic [AddrWidth-1:0]   out_addr_ff;
   logic [TexWidth-1:0]    out_tex_ff;
   logic                   out_last_ff;
   coord_type              u_ff, v_ff, du_ff, dv_ff;
   coord_type              lu_ff, ru_ff, lv_ff, rv_ff;
   coord_type              slu_ff, sru_ff, slv_ff, srv_ff;
   coord_type              nu_ff, nv_ff;
   logic [AddrWidth-1:0]   base_ff;
   logic                   emit, row_end;
   logic [ColWidth-1:0]    col;

   assign col     = cnt_ff[ColWidth-1:0];
   assign emit    = busy_ff && (!out_valid_ff || rsp_tready);
   assign row_end = (col == LastCol);
   assign q_pop   = q_valid && (!busy_ff || (emit && cnt_ff == LastCount));

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_tex_ff, out_addr_ff};
   assign rsp_tlast  = out_last_ff;

   always_comb begin
      busy_in      = busy_ff;
      cnt_in       = cnt_ff;
      out_valid_in = out_valid_ff;
      if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if (emit) begin
         out_valid_in = 1'b1;
         cnt_in       = cnt_ff + 1'b1;
         if (cnt_ff == LastCount) begin
            busy_in = 1'b0;
         end
      end
      if (q_pop) begin
         busy_in = 1'b1;
         cnt_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // next row's inner step, ready long before the row turns over
   always_ff @(posedge clock) begin
      nu_ff <= step_of(lu_ff, ru_ff);
      nv_ff <= step_of(lv_ff, rv_ff);
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         out_addr_ff <= base_ff + {{(AddrWidth-ColWidth){1'b0}}, col};
         out_tex_ff  <= {v_ff[23:16], u_ff[23:16]};
         out_last_ff <= (cnt_ff == LastCount);
      end
      if (q_pop) begin
         u_ff    <= q_data.u;
         v_ff    <= q_data.v;
         du_ff   <= q_data.du;
         dv_ff   <= q_data.dv;
         lu_ff   <= q_data.left_u;
         ru_ff   <= q_data.right_u;
         lv_ff   <= q_data.left_v;
         rv_ff   <= q_data.right_v;
         slu_ff  <= q_data.step_lu;
         sru_ff  <= q_data.step_ru;
         slv_ff  <= q_data.step_lv;
         srv_ff  <= q_data.step_rv;
         base_ff <= q_data.row_base;
      end else if (emit) begin
         if (row_end) begin
            u_ff    <= lu_ff;
            v_ff    <= lv_ff;
            du_ff   <= nu_ff;
            dv_ff   <= nv_ff;
            lu_ff   <= lu_ff + slu_ff;
            ru_ff   <= ru_ff + sru_ff;
            lv_ff   <= lv_ff + slv_ff;
            rv_ff   <= rv_ff + srv_ff;
            base_ff <= base_ff + {{(AddrWidth-LineWidth){1'b0}}, line_width};
         end else begin
            u_ff <= u_ff + du_ff;
            v_ff <= v_ff + dv_ff;
         end
      end
   end

endmodule

`default_nettype wire

### hdl/grid_quad_uv_interpolator_core.sv
`default_nettype none

// Bilinear u/v walker for 8x8 grid cells. Each req beat carries one cell
// (origin and four 16.16 corner coordinates); the block returns 64 rsp beats
// in row-major order, tlast on the 64th. The back-end walker produces one
// pixel per clock while rsp_tready is high; with the next cell queued,
// cells follow back to back with no gap. A two-stage front end works out the
// edge and first-row steps and the row base address and writes the cell into
// a queue of QUEUE_DEPTH cells from its second stage; with the walker idle
// the walker takes the cell from the queue and presents its first rsp beat
// from an output register. line_width is to be written through the csr port
// only while the block is idle, which it does not enforce; csr_ready is always high.
module grid_quad_uv_interpolator_core #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   // origin_x, origin_y, top_left_u, top_left_v, top_right_u, top_right_v,
   // bottom_left_u, bottom_left_v, bottom_right_u, bottom_right_v
   input  wire logic [gqi_pkg::ReqWidth-1:0]  req_tdata,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   // pixel_address, texel_index
   output logic [gqi_pkg::RspWidth-1:0]       rsp_tdata,
   output logic                               rsp_tlast,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [gqi_pkg::LineWidth-1:0] csr_data
);
   import gqi_pkg::*;

   logic [LineWidth-1:0] line_width_ff;
   logic                 q_push, q_ready, q_valid, q_pop;
   cell_type             q_in, q_out;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff <= LineWidthReset;
      end else if (csr_valid) begin
         line_width_ff <= csr_data;
      end
   end

   gqi_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .line_width (line_width_ff),
      .q_push     (q_push),
      .q_ready    (q_ready),
      .q_data     (q_in)
   );

   gqi_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_ready (q_ready),
      .push_data  (q_in),
      .pop_valid  (q_valid),
      .pop        (q_pop),
      .pop_data   (q_out)
   );

   gqi_back u_back (
      .clock      (clock),
      .reset      (reset),
      .line_width (line_width_ff),
      .q_valid    (q_valid),
      .q_pop      (q_pop),
      .q_data     (q_out),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef NO_ASSERTIONS
   a_pop_has_data : assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("walker took a cell from an empty queue");

   a_push_has_room : assert property (@(posedge clock) disable iff (reset)
      q_push && !q_ready |=> q_push)
      else $error("front end dropped a cell while the queue was full");

   a_last_spaced : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> !(rsp_tvalid && rsp_tlast))
      else $error("two last beats in a row");
`endif

endmodule

`default_nettype wire
